// ===== design/lbp_pkg.sv =====
// shared constants and types of the lsb-first bit packer
package lbp_pkg;

	// default field length limit
	localparam int MAX_FIELD_BITS_DEF = 16;
	// fixed widths of the item fields
	localparam int VALUE_W = 16;
	localparam int LEN_W = 5;
	localparam int BYTE_W = 8;
	// accumulator limit: a field never takes more than this minus eight bits
	localparam int ACC_LIMIT = 64;
	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// control flags that travel with each queued item
	typedef struct packed {
		logic fin;   // flush the partial byte after the full bytes
		logic part;  // a partial byte is left over
	} lbp_ctl_t;

	localparam int CTL_W = $bits(lbp_ctl_t);

endpackage

// ===== design/lsb_first_bit_packer.sv =====
// top level of the lsb-first bit packer
// Packs fields of up to MAX_FIELD_BITS bits (Huffman codes optionally bit-reversed,
// extra bits as they are) least significant bit first into bytes. Input items are
// taken one per cycle while the two-entry queue between front and back has room;
// the front merges each field with the pending bits in the cycle it is taken. The
// back sends one result per cycle through its output register while the sink is
// ready; an item sends its full bytes, plus one more result if it is final. A
// final item pads the partial byte with zeros and sends it with tlast; with no
// bits pending it sends a zero byte with tlast and tuser (empty marker) set.
module lsb_first_bit_packer import lbp_pkg::*; #(
	parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // field_value [15:0], field_length [20:16], zero
	input  logic        s_axis_tuser,   // reverse_bits
	input  logic        s_axis_tlast,   // final_req
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // data_byte [7:0]
	output logic        m_axis_tuser,   // empty_res
	output logic        m_axis_tlast    // last
);

	localparam int LEN_MAX = (MAX_FIELD_BITS > ACC_LIMIT-8) ? ACC_LIMIT-8 : MAX_FIELD_BITS;
	localparam int ACC_W = LEN_MAX + 7;
	localparam int NB_W = $clog2(ACC_W / 8 + 1);
	localparam int Q_W = ACC_W + NB_W + CTL_W;

	logic              take;
	logic [ACC_W-1:0]  f_acc;
	logic [NB_W-1:0]   f_nbytes;
	lbp_ctl_t          f_ctl;
	logic              q_not_full;
	logic              q_head_valid;
	logic [Q_W-1:0]    q_head;
	logic              b_pop;
	logic [ACC_W-1:0]  h_acc;
	logic [NB_W-1:0]   h_nbytes;
	lbp_ctl_t          h_ctl;

	assign s_axis_tready = q_not_full;
	assign take = s_axis_tvalid && q_not_full;

	// front: merge the field with the pending bits
	lbp_front #(
		.MAX_FIELD_BITS(MAX_FIELD_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.field_value (s_axis_tdata[15:0]),
		.field_length(s_axis_tdata[20:16]),
		.reverse_bits(s_axis_tuser),
		.final_req   (s_axis_tlast),
		.acc         (f_acc),
		.nbytes      (f_nbytes),
		.ctl         (f_ctl)
	);

	// queue between the two sides
	lbp_queue #(
		.DATA_W(Q_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_data ({f_ctl, f_nbytes, f_acc}),
		.not_full  (q_not_full),
		.pop       (b_pop),
		.head_valid(q_head_valid),
		.head_data (q_head)
	);

	assign h_acc    = q_head[ACC_W-1:0];
	assign h_nbytes = q_head[ACC_W +: NB_W];
	assign h_ctl    = lbp_ctl_t'(q_head[ACC_W+NB_W +: CTL_W]);

	// back: byte-by-byte output
	lbp_back #(
		.ACC_W(ACC_W),
		.NB_W (NB_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_acc   (h_acc),
		.head_nbytes(h_nbytes),
		.head_ctl   (h_ctl),
		.pop        (b_pop),
		.m_valid    (m_axis_tvalid),
		.m_ready    (m_axis_tready),
		.m_byte     (m_axis_tdata),
		.m_last     (m_axis_tlast),
		.m_empty    (m_axis_tuser)
	);

endmodule

// ===== design/lbp_front.sv =====
// front end: masks, reverses and merges each field with the pending bits
module lbp_front import lbp_pkg::*; #(
	parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           take,
	input  logic [VALUE_W-1:0]             field_value,
	input  logic [LEN_W-1:0]               field_length,
	input  logic                           reverse_bits,
	input  logic                           final_req,
	output logic [(((MAX_FIELD_BITS > ACC_LIMIT-8) ? ACC_LIMIT-8 : MAX_FIELD_BITS)+7)-1:0] acc,
	output logic [$clog2(((((MAX_FIELD_BITS > ACC_LIMIT-8) ? ACC_LIMIT-8 : MAX_FIELD_BITS)+7)/8)+1)-1:0] nbytes,
	output lbp_ctl_t                       ctl
);

	localparam int LEN_MAX = (MAX_FIELD_BITS > ACC_LIMIT-8) ? ACC_LIMIT-8 : MAX_FIELD_BITS;
	localparam int FW = LEN_MAX;
	localparam int ACC_W = LEN_MAX + 7;
	localparam int NB_MAX = ACC_W / 8;
	localparam int NB_W = $clog2(NB_MAX + 1);
	localparam int CNT_W = $clog2(ACC_W + 1);
	localparam int PAD_W = BYTE_W * (NB_MAX + 1);

	logic [BYTE_W-2:0] pend_q;
	logic [2:0]        cnt_q;

	logic [LEN_W-1:0]      eff_len;
	logic [FW+VALUE_W-1:0] val_wide;
	logic [FW-1:0]         val_fw;
	logic [FW-1:0]         masked;
	logic [FW-1:0]         rev_full;
	logic [FW-1:0]         field;
	logic [CNT_W-1:0]      total;
	logic [PAD_W-1:0]      acc_pad;
	logic [BYTE_W-1:0]     next_byte;

	// saturate the length to the field limit
	assign eff_len = (int'(field_length) > LEN_MAX) ? LEN_W'(LEN_MAX) : field_length;

	// drop value bits above the length
	assign val_wide = {{FW{1'b0}}, field_value};
	assign val_fw   = val_wide[FW-1:0];
	assign masked   = val_fw & ~({FW{1'b1}} << eff_len);

	// full-width reversal, then slide back down by the unused width
	always_comb begin
		for (int i = 0; i < FW; i++) begin
			rev_full[i] = masked[FW-1-i];
		end
	end
	assign field = reverse_bits ? (rev_full >> (CNT_W'(FW) - CNT_W'(eff_len))) : masked;

	// append above the pending bits
	assign acc    = ACC_W'(pend_q) | (ACC_W'(field) << cnt_q);
	assign total  = CNT_W'(cnt_q) + CNT_W'(eff_len);
	assign nbytes = NB_W'(total >> 3);
	assign ctl.fin  = final_req;
	assign ctl.part = (total[2:0] != 3'd0);

	// byte left over after the full bytes
	assign acc_pad = PAD_W'(acc);
	always_comb begin
		next_byte = '0;
		for (int i = 0; i <= NB_MAX; i++) begin
			if (NB_W'(i) == nbytes) begin
				next_byte = acc_pad[i*BYTE_W +: BYTE_W];
			end
		end
	end

	// pending bits carried to the next item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q  <= '0;
		end else if (take) begin
			if (final_req) begin
				pend_q <= '0;
				cnt_q  <= '0;
			end else begin
				pend_q <= next_byte[BYTE_W-2:0];
				cnt_q  <= total[2:0];
			end
		end
	end

	// bits above the pending count are always clear
	a_pend_clean: assert property (@(posedge clk) disable iff (!arst_n)
		((pend_q >> cnt_q) == '0))
		else $error("pending bits above count");

endmodule

// ===== design/lbp_queue.sv =====
// short queue of merged items between front and back
module lbp_queue import lbp_pkg::*; #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              not_full,
	input  logic              pop,
	output logic              head_valid,
	output logic [DATA_W-1:0] head_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign not_full   = (count_q != CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_q];
	assign do_push    = push && not_full;
	assign do_pop     = pop && head_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : PTR_W'(wr_q + 1'b1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : PTR_W'(rd_q + 1'b1);
			end
			count_q <= count_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

	// fill count stays within the depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= CNT_W'(QUEUE_DEPTH)))
		else $error("queue count beyond depth");

	// a full queue with no pop keeps its count
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!not_full && !pop) |=> !not_full)
		else $error("full queue lost an entry");

endmodule

// ===== design/lbp_back.sv =====
// back end: sends the full bytes of each item and the final byte or marker
module lbp_back import lbp_pkg::*; #(
	parameter int ACC_W = 23,
	parameter int NB_W = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  logic [ACC_W-1:0]  head_acc,
	input  logic [NB_W-1:0]   head_nbytes,
	input  lbp_ctl_t          head_ctl,
	output logic              pop,
	output logic              m_valid,
	input  logic              m_ready,
	output logic [BYTE_W-1:0] m_byte,
	output logic              m_last,
	output logic              m_empty
);

	localparam int NB_MAX = ACC_W / 8;
	localparam int PAD_W = BYTE_W * (NB_MAX + 1);

	logic [NB_W-1:0]   k_q;
	logic              valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;
	logic              empty_q;

	logic [PAD_W-1:0]  acc_pad;
	logic [BYTE_W-1:0] sel_byte;
	logic              load_ok;
	logic              has_byte;
	logic              emit;
	logic              emit_last;
	logic              emit_empty;
	logic              last_full;

	// byte at the current index
	assign acc_pad = PAD_W'(head_acc);
	always_comb begin
		sel_byte = '0;
		for (int i = 0; i <= NB_MAX; i++) begin
			if (NB_W'(i) == k_q) begin
				sel_byte = acc_pad[i*BYTE_W +: BYTE_W];
			end
		end
	end

	// what is loaded into the output register this cycle
	assign load_ok    = !valid_q || m_ready;
	assign has_byte   = (k_q != head_nbytes);
	assign last_full  = (NB_W'(k_q + 1'b1) == head_nbytes);
	assign emit       = head_valid && load_ok && (has_byte || head_ctl.fin);
	assign emit_last  = !has_byte;
	assign emit_empty = !has_byte && !head_ctl.part;

	always_comb begin
		pop = 1'b0;
		if (head_valid) begin
			if (has_byte) begin
				pop = load_ok && last_full && !head_ctl.fin;
			end else if (head_ctl.fin) begin
				pop = load_ok;
			end else begin
				pop = 1'b1;
			end
		end
	end

	// byte index within the head item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (pop) begin
			k_q <= '0;
		end else if (emit) begin
			k_q <= NB_W'(k_q + 1'b1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit) begin
			valid_q <= 1'b1;
		end else if (m_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q  <= emit_empty ? '0 : sel_byte;
			last_q  <= emit_last;
			empty_q <= emit_empty;
		end
	end

	assign m_valid = valid_q;
	assign m_byte  = byte_q;
	assign m_last  = last_q;
	assign m_empty = empty_q;

	// a marker result is always last and carries a zero byte
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && empty_q) |-> (last_q && byte_q == '0))
		else $error("marker result malformed");

	// the byte index never runs past the head item's byte count
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (k_q <= head_nbytes))
		else $error("byte index beyond item");

	// nothing is loaded over a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !m_ready) |-> !emit)
		else $error("result overwritten");

endmodule
